// ===== src/qoi_pkg.sv =====
`timescale 1ns / 1ps

package qoi_pkg;

    localparam int QW = 18;                      // quaternion component, Q2.16
    localparam int OW = 24;                      // angular velocity, Q8.16
    localparam int TW = 16;                      // time step, Q0.16
    localparam int MULW = QW + OW;               // one term of the Hamilton product
    localparam int PW = MULW + 2;                // sum of three terms
    localparam int DW = PW + TW + 1;             // product term times time step
    localparam int SW = 28;                      // updated, not yet normalised component
    localparam int SQW = 2 * SW;                 // square of one component
    localparam int MW = 58;                      // sum of squares, padded to an even width
    localparam int KW = 5;                       // index of the leading bit pair
    localparam int VW = 32;                      // normalised norm, Q2.30
    localparam int YW = 32;                      // inverse square root estimate, Q.30
    localparam int Y2W = 34;
    localparam int TTW = 36;
    localparam int FW = 61;                      // component times estimate
    localparam int SHW = 6;

    localparam int RSQRT_ITERATIONS_DEF = 3;

    localparam logic [TW-1:0] TIME_STEP_RESET = 16'd1092;
    localparam logic [KW-1:0] KEY_PAIR = 5'd15;  // pair that holds bits 31:30 of v
    localparam logic [SHW-1:0] SH_BASE = 6'd14;
    localparam logic [TTW-1:0] THREE_Q30 = 36'd3 << 30;
    localparam logic signed [QW-1:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [QW-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [QW-1:0] OUT_MIN = -18'sd131072;

    typedef logic signed [SW-1:0] sval_t;

    // Side information that travels alongside the arithmetic through every stage.
    typedef struct packed {
        logic            hold;
        logic            zero;
        logic [SHW-1:0]  sh;
        sval_t [3:0]     s;
    } carry_t;

    // Seed for the inverse square root, chosen by the top four bits of v in [1, 4).
    function automatic logic [15:0] rsqrt_seed(input logic [3:0] top);
        logic [15:0] r;
        case (top)
            4'd4:    r = 16'd61788;
            4'd5:    r = 16'd55889;
            4'd6:    r = 16'd51411;
            4'd7:    r = 16'd47861;
            4'd8:    r = 16'd44957;
            4'd9:    r = 16'd42525;
            4'd10:   r = 16'd40450;
            4'd11:   r = 16'd38651;
            4'd12:   r = 16'd37073;
            4'd13:   r = 16'd35674;
            4'd14:   r = 16'd34421;
            4'd15:   r = 16'd33292;
            default: r = 16'd61788;
        endcase
        return r;
    endfunction

endpackage

// ===== src/qoi_item_if.sv =====
`timescale 1ns / 1ps

interface qoi_item_if import qoi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [QW-1:0]  quat_w;
    logic signed [QW-1:0]  quat_x;
    logic signed [QW-1:0]  quat_y;
    logic signed [QW-1:0]  quat_z;
    logic signed [OW-1:0]  omega_x;
    logic signed [OW-1:0]  omega_y;
    logic signed [OW-1:0]  omega_z;
    logic                  lock_tilt;
    logic                  hold;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, omega_x, omega_y, omega_z,
                   lock_tilt, hold, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, omega_x, omega_y, omega_z,
                 lock_tilt, hold, output ready);
endinterface

// ===== src/qoi_result_if.sv =====
`timescale 1ns / 1ps

interface qoi_result_if import qoi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [QW-1:0]  new_w;
    logic signed [QW-1:0]  new_x;
    logic signed [QW-1:0]  new_y;
    logic signed [QW-1:0]  new_z;

    modport source(output valid, new_w, new_x, new_y, new_z, input ready);
    modport sink(input valid, new_w, new_x, new_y, new_z, output ready);
endinterface

// ===== src/qoi_rsqrt_step.sv =====
`timescale 1ns / 1ps

// One Newton step y = y * (3 - v * y^2) / 2 over three register stages.
module qoi_rsqrt_step import qoi_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [VW-1:0]  in_v,
    input  logic [YW-1:0]  in_y,
    input  carry_t         in_c,
    output logic           out_vld,
    output logic [VW-1:0]  out_v,
    output logic [YW-1:0]  out_y,
    output carry_t         out_c
);

    logic [2:0]      vld_reg;
    carry_t          c_reg [3];
    logic [VW-1:0]   v_reg [2];
    logic [YW-1:0]   y_reg [2];
    logic [Y2W-1:0]  y2_reg;
    logic [TTW-1:0]  t_reg;
    logic [YW-1:0]   yn_reg;
    logic [VW-1:0]   vn_reg;

    logic [2*YW-1:0]     yy;
    logic [VW+Y2W-1:0]   vy2;
    logic [TTW-1:0]      h_wide;
    logic [YW-1:0]       h;
    logic [2*YW-1:0]     yh;

    always_comb
    begin
        yy = in_y * in_y;
        vy2 = (VW+Y2W)'(v_reg[0]) * (VW+Y2W)'(y2_reg);
        h_wide = (t_reg >= THREE_Q30) ? '0 : THREE_Q30 - t_reg;
        h = h_wide[YW-1:0];
        yh = y_reg[1] * h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg <= yy[Y2W+29:30];
            v_reg[0] <= in_v;
            y_reg[0] <= in_y;
            c_reg[0] <= in_c;

            t_reg <= vy2[TTW+29:30];
            v_reg[1] <= v_reg[0];
            y_reg[1] <= y_reg[0];
            c_reg[1] <= c_reg[0];

            yn_reg <= yh[YW+30:31];
            vn_reg <= v_reg[1];
            c_reg[2] <= c_reg[1];
        end
    end

    assign out_vld = vld_reg[2];
    assign out_v = vn_reg;
    assign out_y = yn_reg;
    assign out_c = c_reg[2];

endmodule

// ===== src/quaternion_orientation_integrator.sv =====
`timescale 1ns / 1ps

// Channel   Role    Contents
// item      sink    quat_w..z (Q2.16), omega_x..z (Q8.16), lock_tilt, hold
// result    source  new_w..z (Q2.16), normalised and saturated unless hold is set
// cfg       write   cfg_wr_en, cfg_wr_data: time_step (Q0.16)
//
// One transaction is taken per cycle while the result register is not stalled; the pipeline
// has nine front stages, three stages per Newton step and three output stages.
// Reset clears the valid bits and loads time_step with its reset value.
// A stalled result register freezes the whole pipeline, so nothing is lost or repeated.
module quaternion_orientation_integrator import qoi_pkg::*;
#(
    parameter int RSQRT_ITERATIONS = RSQRT_ITERATIONS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [TW-1:0]  cfg_wr_data,
    qoi_item_if.sink       item,
    qoi_result_if.source   result
);

    logic            adv;
    logic [TW-1:0]   time_step_reg;
    logic [8:0]      s_vld_reg;
    carry_t          c_reg [9];
    carry_t          c_next [9];

    logic signed [OW-1:0]    ox, oy, oz;
    logic signed [MULW-1:0]  mul_next [12];
    logic signed [MULW-1:0]  mul_reg [12];
    logic signed [PW-1:0]    p_next [4];
    logic signed [PW-1:0]    p_reg [4];
    logic signed [DW-1:0]    d_next [4];
    logic signed [DW-1:0]    d_reg [4];
    logic signed [DW-1:0]    rnd [4];
    logic signed [SQW-1:0]   sq_next [4];
    logic signed [SQW-1:0]   sq_reg [4];
    logic [MW-1:0]           m_next;
    logic [MW-1:0]           m_reg;
    logic [MW-1:0]           m7_reg;
    logic [KW-1:0]           k_next;
    logic [KW-1:0]           k_reg;
    logic [MW-1:0]           v_wide;
    logic [VW-1:0]           v8_reg;
    logic [VW-1:0]           v9_reg;
    logic [YW-1:0]           y9_reg;

    logic                    ry_vld [RSQRT_ITERATIONS+1];
    logic [VW-1:0]           ry_v [RSQRT_ITERATIONS+1];
    logic [YW-1:0]           ry_y [RSQRT_ITERATIONS+1];
    carry_t                  ry_c [RSQRT_ITERATIONS+1];

    logic [2:0]              f_vld_reg;
    carry_t                  fc_reg [3];
    logic signed [FW-1:0]    prod_next [4];
    logic signed [FW-1:0]    prod_reg [4];
    logic signed [FW-1:0]    res_next [4];
    logic signed [FW-1:0]    res_reg [4];
    logic signed [QW-1:0]    out_next [4];
    logic signed [QW-1:0]    out_reg [4];

    assign adv = !f_vld_reg[2] || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            time_step_reg <= cfg_wr_data;
        end
    end

    // Front end: Hamilton product, time step, squares, norm and seed.
    always_comb
    begin
        ox = item.lock_tilt ? '0 : item.omega_x;
        oy = item.lock_tilt ? '0 : item.omega_y;
        oz = item.omega_z;
        mul_next[0]  = ox * item.quat_x;
        mul_next[1]  = oy * item.quat_y;
        mul_next[2]  = oz * item.quat_z;
        mul_next[3]  = ox * item.quat_w;
        mul_next[4]  = oy * item.quat_z;
        mul_next[5]  = oz * item.quat_y;
        mul_next[6]  = ox * item.quat_z;
        mul_next[7]  = oy * item.quat_w;
        mul_next[8]  = oz * item.quat_x;
        mul_next[9]  = ox * item.quat_y;
        mul_next[10] = oy * item.quat_x;
        mul_next[11] = oz * item.quat_w;

        p_next[0] = -(PW'(mul_reg[0]) + PW'(mul_reg[1]) + PW'(mul_reg[2]));
        p_next[1] = PW'(mul_reg[3]) + PW'(mul_reg[4]) - PW'(mul_reg[5]);
        p_next[2] = -PW'(mul_reg[6]) + PW'(mul_reg[7]) + PW'(mul_reg[8]);
        p_next[3] = PW'(mul_reg[9]) - PW'(mul_reg[10]) + PW'(mul_reg[11]);

        c_next[0].hold = item.hold;
        c_next[0].zero = 1'b0;
        c_next[0].sh = '0;
        c_next[0].s[0] = SW'(item.quat_w);
        c_next[0].s[1] = SW'(item.quat_x);
        c_next[0].s[2] = SW'(item.quat_y);
        c_next[0].s[3] = SW'(item.quat_z);
        for (int i = 1; i < 9; i++)
        begin
            c_next[i] = c_reg[i-1];
        end

        m_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            d_next[i] = DW'(p_reg[i]) * DW'($signed({1'b0, time_step_reg}));
            // The half factor sits in the shift by 33; rounding is half up.
            rnd[i] = d_reg[i] + (DW'(1) <<< 32);
            if (!c_reg[2].hold)
            begin
                c_next[3].s[i] = $signed(c_reg[2].s[i]) + $signed(rnd[i][DW-1:33]);
            end
            sq_next[i] = $signed(c_reg[3].s[i]) * $signed(c_reg[3].s[i]);
            m_next = m_next + MW'($unsigned(sq_reg[i]));
        end
        c_next[5].zero = (m_next == '0);

        k_next = '0;
        for (int i = 0; i < MW / 2; i++)
        begin
            if (m_reg[2*i+1] || m_reg[2*i])
            begin
                k_next = KW'(i);
            end
        end
        c_next[7].sh = SHW'(k_reg) + SH_BASE;
        if (k_reg >= KEY_PAIR)
        begin
            v_wide = m7_reg >> {k_reg - KEY_PAIR, 1'b0};
        end
        else
        begin
            v_wide = m7_reg << {KEY_PAIR - k_reg, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= '0;
        end
        else if (adv)
        begin
            s_vld_reg <= {s_vld_reg[7:0], item.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                c_reg[i] <= c_next[i];
            end
            for (int i = 0; i < 12; i++)
            begin
                mul_reg[i] <= mul_next[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                p_reg[i] <= p_next[i];
                d_reg[i] <= d_next[i];
                sq_reg[i] <= sq_next[i];
            end
            m_reg <= m_next;
            k_reg <= k_next;
            m7_reg <= m_reg;
            v8_reg <= v_wide[VW-1:0];
            v9_reg <= v8_reg;
            y9_reg <= YW'(rsqrt_seed(v8_reg[VW-1:VW-4])) << 14;
        end
    end

    assign ry_vld[0] = s_vld_reg[8];
    assign ry_v[0] = v9_reg;
    assign ry_y[0] = y9_reg;
    assign ry_c[0] = c_reg[8];

    for (genvar g = 0; g < RSQRT_ITERATIONS; g++)
    begin : g_step
        qoi_rsqrt_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (ry_vld[g]),
            .in_v    (ry_v[g]),
            .in_y    (ry_y[g]),
            .in_c    (ry_c[g]),
            .out_vld (ry_vld[g+1]),
            .out_v   (ry_v[g+1]),
            .out_y   (ry_y[g+1]),
            .out_c   (ry_c[g+1])
        );
    end

    // Back end: scale by the estimate, round by the leading pair index plus 14, saturate and select.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = FW'($signed(ry_c[RSQRT_ITERATIONS].s[i]))
                         * FW'($signed({1'b0, ry_y[RSQRT_ITERATIONS]}));
            res_next[i] = (prod_reg[i] + (FW'(1) <<< (fc_reg[0].sh - SHW'(1))))
                        >>> fc_reg[0].sh;
            if (fc_reg[1].hold)
            begin
                out_next[i] = fc_reg[1].s[i][QW-1:0];
            end
            else if (fc_reg[1].zero)
            begin
                out_next[i] = (i == 0) ? ONE_Q16 : '0;
            end
            else if (res_reg[i] > FW'(OUT_MAX))
            begin
                out_next[i] = OUT_MAX;
            end
            else if (res_reg[i] < FW'(OUT_MIN))
            begin
                out_next[i] = OUT_MIN;
            end
            else
            begin
                out_next[i] = res_reg[i][QW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
        end
        else if (adv)
        begin
            f_vld_reg <= {f_vld_reg[1:0], ry_vld[RSQRT_ITERATIONS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fc_reg[0] <= ry_c[RSQRT_ITERATIONS];
            fc_reg[1] <= fc_reg[0];
            fc_reg[2] <= fc_reg[1];
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= prod_next[i];
                res_reg[i] <= res_next[i];
                out_reg[i] <= out_next[i];
            end
        end
    end

    assign result.valid = f_vld_reg[2];
    assign result.new_w = out_reg[0];
    assign result.new_x = out_reg[1];
    assign result.new_y = out_reg[2];
    assign result.new_z = out_reg[3];

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready == (!result.valid || result.ready))
        else $error("input ready does not follow the output stall");

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        s_vld_reg[7] && !c_reg[7].zero && !c_reg[7].hold |-> v8_reg[VW-1:VW-2] != 2'b00)
        else $error("normalised norm outside [1, 4)");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && fc_reg[2].zero && !fc_reg[2].hold
        |-> result.new_w == ONE_Q16 && result.new_x == '0
            && result.new_y == '0 && result.new_z == '0)
        else $error("zero norm did not give the unit quaternion");

endmodule
